// File: rtl/longest_prefix_match_route_table_assert.svh
// assertion macros shared by the route table modules
`ifndef LONGEST_PREFIX_MATCH_ROUTE_TABLE_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_ROUTE_TABLE_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define LPM_ASSERT_NOW(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
        else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define LPM_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lpm_pkg.sv
package lpm_pkg;

    // table size and derived widths
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // fixed field widths
    localparam int ADDR_W = 32;
    localparam int PORT_W = 4;
    localparam int SLOT_W = 4;

    // item opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } entry_t;

    // running best candidate fed back to the compare unit
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] mask;
    } best_t;

    typedef struct packed {
        logic matched;
        logic take;
    } cmp_t;

endpackage

// File: rtl/lpm_table.sv
`include "longest_prefix_match_route_table_assert.svh"

module lpm_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [lpm_pkg::IDX_W-1:0]   wr_slot,
    input  lpm_pkg::entry_t             wr_entry,
    input  logic [lpm_pkg::IDX_W-1:0]   rd_slot,
    output lpm_pkg::entry_t             rd_entry
);

    logic [lpm_pkg::TABLE_DEPTH-1:0]   valid_reg;
    logic [lpm_pkg::ADDR_W-1:0]        prefix_reg  [lpm_pkg::TABLE_DEPTH];
    logic [lpm_pkg::ADDR_W-1:0]        mask_reg    [lpm_pkg::TABLE_DEPTH];
    logic [lpm_pkg::ADDR_W-1:0]        gateway_reg [lpm_pkg::TABLE_DEPTH];
    logic [lpm_pkg::PORT_W-1:0]        port_reg    [lpm_pkg::TABLE_DEPTH];

    // valid marks cleared by reset, payload left as is
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_slot] <= wr_entry.valid;
        end
        if (wr_en) begin
            prefix_reg[wr_slot]  <= wr_entry.prefix;
            mask_reg[wr_slot]    <= wr_entry.mask;
            gateway_reg[wr_slot] <= wr_entry.gateway;
            port_reg[wr_slot]    <= wr_entry.port;
        end
    end

    always_comb begin
        rd_entry.valid   = valid_reg[rd_slot];
        rd_entry.prefix  = prefix_reg[rd_slot];
        rd_entry.mask    = mask_reg[rd_slot];
        rd_entry.gateway = gateway_reg[rd_slot];
        rd_entry.port    = port_reg[rd_slot];
    end

    `LPM_ASSERT_NEXT(a_valid_written, aclk, aresetn, wr_en, valid_reg[$past(wr_slot)] == $past(wr_entry.valid), "valid mark not stored")

endmodule

// File: rtl/lpm_match_unit.sv
module lpm_match_unit (
    input  lpm_pkg::entry_t             entry,
    input  logic [lpm_pkg::ADDR_W-1:0]  address,
    input  lpm_pkg::best_t              best,
    output lpm_pkg::cmp_t               cmp
);

    // masked compare, then rank by numeric mask value
    always_comb begin
        cmp.matched = entry.valid && (((address ^ entry.prefix) & entry.mask) == '0);
        cmp.take    = cmp.matched && (!best.found || (entry.mask > best.mask));
    end

endmodule

// File: rtl/longest_prefix_match_route_table.sv
// IPv4 longest-prefix-match route table of lpm_pkg::TABLE_DEPTH entries (16).
// Write items (op = 0) store prefix, mask, gateway, port and valid mark in one
// slot in the cycle they transfer and give no result; a slot at or above the
// table depth is ignored. Lookup items (op = 1) give one result each: the
// table is scanned one slot per cycle through a single masked-compare and
// mask-rank unit, so s_ready stays low after a lookup transfers, through the
// scan of every slot and the move of the winner into the output register,
// and longer when the previous result still waits for m_ready. The scan is
// what sets the rate.
// The largest numeric mask wins, the lowest slot on a tie; with no match hit
// and all other result fields are zero. After reset no entry is valid. The
// output register lets a new item transfer while a result waits for m_ready.

`include "longest_prefix_match_route_table_assert.svh"

module longest_prefix_match_route_table (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [3:0]                  s_entry_index,
    input  logic                        s_entry_valid,
    input  logic [31:0]                 s_route_prefix,
    input  logic [31:0]                 s_route_mask,
    input  logic [31:0]                 s_route_gateway,
    input  logic [3:0]                  s_route_port,
    input  logic [31:0]                 s_lookup_address,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [3:0]                  m_match_index,
    output logic [31:0]                 m_next_gateway,
    output logic [3:0]                  m_out_port
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t                             state_reg, state_next;
    logic [lpm_pkg::IDX_W-1:0]          scan_idx_reg, scan_idx_next;
    logic [lpm_pkg::ADDR_W-1:0]         addr_reg, addr_next;
    logic                               found_reg, found_next;
    logic [lpm_pkg::IDX_W-1:0]          best_idx_reg, best_idx_next;
    logic [lpm_pkg::ADDR_W-1:0]         best_mask_reg, best_mask_next;
    logic [lpm_pkg::ADDR_W-1:0]         best_gw_reg, best_gw_next;
    logic [lpm_pkg::PORT_W-1:0]         best_port_reg, best_port_next;

    logic                               m_valid_reg, m_valid_next;
    logic                               m_hit_reg, m_hit_next;
    logic [lpm_pkg::SLOT_W-1:0]         m_index_reg, m_index_next;
    logic [lpm_pkg::ADDR_W-1:0]         m_gw_reg, m_gw_next;
    logic [lpm_pkg::PORT_W-1:0]         m_port_reg, m_port_next;

    logic                               in_xfer;
    logic                               wr_en;
    logic [lpm_pkg::IDX_W-1:0]          wr_slot;
    lpm_pkg::entry_t                    wr_entry;
    lpm_pkg::entry_t                    rd_entry;
    lpm_pkg::best_t                     best;
    lpm_pkg::cmp_t                      cmp;
    logic                               out_free;

    // input side is open only between lookups
    assign s_ready = (state_reg == ST_IDLE);
    assign in_xfer = s_valid && s_ready;

    // write items go straight into the table
    assign wr_en   = in_xfer && (s_op == lpm_pkg::OP_WRITE)
                     && (32'(s_entry_index) < lpm_pkg::TABLE_DEPTH);
    assign wr_slot = lpm_pkg::IDX_W'(s_entry_index);

    always_comb begin
        wr_entry.valid   = s_entry_valid;
        wr_entry.prefix  = s_route_prefix;
        wr_entry.mask    = s_route_mask;
        wr_entry.gateway = s_route_gateway;
        wr_entry.port    = s_route_port;
    end

    lpm_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_slot  (wr_slot),
        .wr_entry (wr_entry),
        .rd_slot  (scan_idx_reg),
        .rd_entry (rd_entry)
    );

    // one compare per cycle against the running best
    always_comb begin
        best.found = found_reg;
        best.mask  = best_mask_reg;
    end

    lpm_match_unit u_match (
        .entry   (rd_entry),
        .address (addr_reg),
        .best    (best),
        .cmp     (cmp)
    );

    // output register is free when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        addr_next      = addr_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_mask_next = best_mask_reg;
        best_gw_next   = best_gw_reg;
        best_port_next = best_port_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_hit_next     = m_hit_reg;
        m_index_next   = m_index_reg;
        m_gw_next      = m_gw_reg;
        m_port_next    = m_port_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && (s_op == lpm_pkg::OP_LOOKUP)) begin
                    addr_next      = s_lookup_address;
                    scan_idx_next  = '0;
                    found_next     = 1'b0;
                    best_mask_next = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmp.take) begin
                    found_next     = 1'b1;
                    best_idx_next  = scan_idx_reg;
                    best_mask_next = rd_entry.mask;
                    best_gw_next   = rd_entry.gateway;
                    best_port_next = rd_entry.port;
                end
                if (scan_idx_reg == lpm_pkg::LAST_IDX) begin
                    state_next = ST_RESULT;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_RESULT: begin
                // wait here until the previous result has been taken
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = found_reg;
                    m_index_next = found_reg ? lpm_pkg::SLOT_W'(best_idx_reg) : '0;
                    m_gw_next    = found_reg ? best_gw_reg : '0;
                    m_port_next  = found_reg ? best_port_reg : '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        scan_idx_reg  <= scan_idx_next;
        addr_reg      <= addr_next;
        found_reg     <= found_next;
        best_idx_reg  <= best_idx_next;
        best_mask_reg <= best_mask_next;
        best_gw_reg   <= best_gw_next;
        best_port_reg <= best_port_next;
        m_hit_reg     <= m_hit_next;
        m_index_reg   <= m_index_next;
        m_gw_reg      <= m_gw_next;
        m_port_reg    <= m_port_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_match_index  = m_index_reg;
    assign m_next_gateway = m_gw_reg;
    assign m_out_port     = m_port_reg;

    `LPM_ASSERT_NEXT(a_lookup_starts_scan, aclk, aresetn, in_xfer && (s_op == lpm_pkg::OP_LOOKUP), (state_reg == ST_SCAN) && (scan_idx_reg == '0) && !found_reg, "lookup did not start a scan at slot zero")
    `LPM_ASSERT_NEXT(a_scan_ends, aclk, aresetn, (state_reg == ST_SCAN) && (scan_idx_reg == lpm_pkg::LAST_IDX), state_reg == ST_RESULT, "scan did not end after the last slot")
    `LPM_ASSERT_NOW(a_miss_is_zero, aclk, aresetn, m_valid_reg && !m_hit_reg, (m_index_reg == '0) && (m_gw_reg == '0) && (m_port_reg == '0), "miss result carries nonzero fields")

endmodule
